### hdl/etig_pkg.sv
// Package for the extrusion triangle index generator.
// Holds the fixed field widths, the part codes and the register map.
// No dependencies.
package etig_pkg;

  localparam int RING_W  = 6;
  localparam int SPINE_W = 9;
  localparam int IDX_W   = 13;
  localparam int PART_W  = 2;
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;
  localparam int REG_W   = 3;

  typedef enum logic [PART_W-1:0] {
    PART_SIDE  = 2'd0,
    PART_BEGIN = 2'd1,
    PART_END   = 2'd2
  } part_t;

  typedef logic [REG_W-1:0] reg_idx_t;

  localparam reg_idx_t REG_RING_SIZE    = 3'd0;
  localparam reg_idx_t REG_SPINE_POINTS = 3'd1;
  localparam reg_idx_t REG_RING_CLOSED  = 3'd2;
  localparam reg_idx_t REG_SPINE_LOOP   = 3'd3;
  localparam reg_idx_t REG_BEGIN_CAP_ON = 3'd4;
  localparam reg_idx_t REG_END_CAP_ON   = 3'd5;

  localparam logic [RING_W-1:0]  RING_SIZE_RST    = 6'd32;
  localparam logic [SPINE_W-1:0] SPINE_POINTS_RST = 9'd2;

endpackage

### hdl/etig_req_if.sv
// Request channel of the triangle index generator: one restart flag per word.
// Depends on nothing.
interface etig_req_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

### hdl/etig_tri_if.sv
// Triangle channel of the triangle index generator: three vertex indices,
// the part code and the final-triangle mark per word. Depends on etig_pkg.
interface etig_tri_if;
  logic                        valid;
  logic                        ready;
  logic [etig_pkg::IDX_W-1:0]  corner_a;
  logic [etig_pkg::IDX_W-1:0]  corner_b;
  logic [etig_pkg::IDX_W-1:0]  corner_c;
  logic [etig_pkg::PART_W-1:0] part;
  logic                        last_triangle;

  modport source (output valid, output corner_a, output corner_b, output corner_c,
                  output part, output last_triangle, input ready);
  modport sink (input valid, input corner_a, input corner_b, input corner_c,
                input part, input last_triangle, output ready);
endinterface

### hdl/extrusion_triangle_index_generator.sv
// Top level of the extrusion triangle index generator.
// Depends on etig_pkg, etig_req_if and etig_tri_if.
//
// Each word taken on the request channel yields one triangle word on the
// triangle channel: side bands first, then the begin cap fan, then the end
// cap fan, with last_triangle set on the final triangle of the mesh. A word
// with restart set begins the mesh again; otherwise the next triangle follows,
// and the word after the final triangle wraps to the first one.
// The mesh shape is set through the APB port; the user must write it only while
// the block is idle, which the block itself does not enforce. pready is always
// high and reads return the register contents. The triangle is in the output
// register on the cycle after its request is taken. One request is taken every
// cycle unless the receiver stalls, as the whole index calculation (two small
// multiplies, adds and compares) sits between the position and output registers.
// When the receiver stalls, the output register holds its word and request
// ready stays high only while that word is being taken on the same edge.
// Reset empties the output register, restores the register defaults and
// returns the position to the first triangle.
module extrusion_triangle_index_generator #(
  parameter int MAX_RING  = 32,
  parameter int MAX_SPINE = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [etig_pkg::ADDR_W-1:0]   paddr,
  input  logic [etig_pkg::DATA_W-1:0]   pwdata,
  output logic [etig_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  etig_req_if.sink                      request,
  etig_tri_if.source                    triangle
);
  import etig_pkg::*;

  localparam int RW = $clog2(MAX_RING + 1);
  localparam int SW = $clog2(MAX_SPINE + 1);
  localparam int PW = RW + SW;

  typedef struct packed {
    part_t         phase;
    logic [SW-1:0] band;
    logic [RW-1:0] slot;
    logic          half;
  } pos_t;

  localparam pos_t POS_START = '{phase: PART_SIDE, band: '0, slot: '0, half: 1'b0};

  logic [RING_W-1:0]  ring_size;
  logic [SPINE_W-1:0] spine_points;
  logic               ring_closed;
  logic               spine_loop;
  logic               begin_cap_on;
  logic               end_cap_on;

  logic [RW-1:0] r_eff;
  logic [SW-1:0] s_eff;
  logic [SW-1:0] bands;
  logic [RW-1:0] quads;
  logic [RW-1:0] fan;

  pos_t pos;
  pos_t pos_next;
  pos_t cur;
  pos_t adv;

  logic [PW-1:0]    lo;
  logic [PW-1:0]    anchor;
  logic [RW-1:0]    inext;
  logic             hi_zero;
  logic [IDX_W-1:0] lo_idx;
  logic [IDX_W-1:0] hi_idx;
  logic [IDX_W-1:0] anc_idx;
  logic [IDX_W-1:0] a_next;
  logic [IDX_W-1:0] b_next;
  logic [IDX_W-1:0] c_next;
  logic             last_next;

  logic             out_valid;
  logic [IDX_W-1:0] corner_a;
  logic [IDX_W-1:0] corner_b;
  logic [IDX_W-1:0] corner_c;
  part_t            part;
  logic             last_triangle;

  logic     accept;
  logic     cfg_write;
  reg_idx_t reg_idx;

  // Moves a position forward until it names a triangle that exists.
  function automatic pos_t settle(pos_t p, logic [SW-1:0] nb, logic [RW-1:0] nq,
                                  logic [RW-1:0] nf, logic bc, logic ec);
    pos_t q;
    q = p;
    if (q.phase == PART_SIDE && q.band < nb && q.slot >= nq) begin
      q.band = q.band + 1'b1;
      q.slot = '0;
      q.half = 1'b0;
    end
    if (q.phase == PART_SIDE && q.band >= nb) begin
      q.phase = PART_BEGIN;
      q.slot  = '0;
      q.half  = 1'b0;
    end
    if (q.phase == PART_BEGIN && !(bc && q.slot < nf)) begin
      q.phase = PART_END;
      q.slot  = '0;
    end
    if (q.phase == PART_END && !(ec && q.slot < nf)) begin
      q = POS_START;
    end
    return q;
  endfunction

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign reg_idx   = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_size    <= RING_SIZE_RST;
      spine_points <= SPINE_POINTS_RST;
      ring_closed  <= 1'b1;
      spine_loop   <= 1'b0;
      begin_cap_on <= 1'b1;
      end_cap_on   <= 1'b1;
    end else if (cfg_write) begin
      unique case (reg_idx)
        REG_RING_SIZE:    ring_size    <= pwdata[RING_W-1:0];
        REG_SPINE_POINTS: spine_points <= pwdata[SPINE_W-1:0];
        REG_RING_CLOSED:  ring_closed  <= pwdata[0];
        REG_SPINE_LOOP:   spine_loop   <= pwdata[0];
        REG_BEGIN_CAP_ON: begin_cap_on <= pwdata[0];
        REG_END_CAP_ON:   end_cap_on   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_RING_SIZE:    prdata = DATA_W'(ring_size);
      REG_SPINE_POINTS: prdata = DATA_W'(spine_points);
      REG_RING_CLOSED:  prdata = DATA_W'(ring_closed);
      REG_SPINE_LOOP:   prdata = DATA_W'(spine_loop);
      REG_BEGIN_CAP_ON: prdata = DATA_W'(begin_cap_on);
      REG_END_CAP_ON:   prdata = DATA_W'(end_cap_on);
      default:          prdata = '0;
    endcase
  end

  always_comb begin
    if (ring_size < RING_W'(3)) begin
      r_eff = RW'(3);
    end else if (32'(ring_size) > MAX_RING) begin
      r_eff = RW'(MAX_RING);
    end else begin
      r_eff = RW'(ring_size);
    end
    if (spine_points < SPINE_W'(2)) begin
      s_eff = SW'(2);
    end else if (32'(spine_points) > MAX_SPINE) begin
      s_eff = SW'(MAX_SPINE);
    end else begin
      s_eff = SW'(spine_points);
    end
  end

  assign bands = spine_loop ? s_eff : s_eff - 1'b1;
  assign quads = ring_closed ? r_eff : r_eff - 1'b1;
  assign fan   = r_eff - RW'(2);

  assign cur = settle(request.restart ? POS_START : pos, bands, quads, fan,
                      begin_cap_on, end_cap_on);

  assign lo      = PW'(cur.band) * PW'(r_eff);
  assign anchor  = PW'(s_eff - 1'b1) * PW'(r_eff);
  assign hi_zero = (SW + 1)'(cur.band) + 1'b1 >= (SW + 1)'(s_eff);
  assign inext   = (cur.slot + 1'b1 >= r_eff) ? '0 : cur.slot + 1'b1;
  assign lo_idx  = IDX_W'(lo);
  assign hi_idx  = hi_zero ? '0 : lo_idx + IDX_W'(r_eff);
  assign anc_idx = IDX_W'(anchor);

  always_comb begin
    adv = cur;
    unique case (cur.phase)
      PART_SIDE: begin
        a_next    = lo_idx + IDX_W'(cur.slot);
        b_next    = cur.half ? hi_idx + IDX_W'(inext) : lo_idx + IDX_W'(inext);
        c_next    = cur.half ? hi_idx + IDX_W'(cur.slot) : hi_idx + IDX_W'(inext);
        last_next = cur.band == bands - 1'b1 && cur.slot == quads - 1'b1 &&
                    cur.half && !begin_cap_on && !end_cap_on;
        adv.half  = !cur.half;
        if (cur.half) begin
          adv.slot = cur.slot + 1'b1;
        end
      end
      PART_BEGIN: begin
        a_next    = '0;
        b_next    = IDX_W'(r_eff - RW'(1) - cur.slot);
        c_next    = IDX_W'(r_eff - RW'(2) - cur.slot);
        last_next = cur.slot == r_eff - RW'(3) && !end_cap_on;
        adv.slot  = cur.slot + 1'b1;
      end
      default: begin
        a_next    = anc_idx;
        b_next    = anc_idx + IDX_W'(cur.slot) + IDX_W'(1);
        c_next    = anc_idx + IDX_W'(cur.slot) + IDX_W'(2);
        last_next = cur.slot == r_eff - RW'(3);
        adv.slot  = cur.slot + 1'b1;
      end
    endcase
  end

  assign pos_next = settle(adv, bands, quads, fan, begin_cap_on, end_cap_on);

  assign request.ready = !out_valid || triangle.ready;
  assign accept        = request.valid && request.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= POS_START;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        pos       <= pos_next;
        out_valid <= 1'b1;
      end else if (triangle.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      corner_a      <= a_next;
      corner_b      <= b_next;
      corner_c      <= c_next;
      part          <= cur.phase;
      last_triangle <= last_next;
    end
  end

  assign triangle.valid         = out_valid;
  assign triangle.corner_a      = corner_a;
  assign triangle.corner_b      = corner_b;
  assign triangle.corner_c      = corner_c;
  assign triangle.part          = part;
  assign triangle.last_triangle = last_triangle;

endmodule

### tb/sv/tb_top.sv
// Testbench for the extrusion triangle index generator: sets the mesh shape over
// APB, sends request words, predicts every triangle word and compares it field by field.
// Depends on etig_pkg, etig_req_if, etig_tri_if and extrusion_triangle_index_generator.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import etig_pkg::*;

  localparam int MAX_RING    = 32;
  localparam int MAX_SPINE   = 256;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 60;
  localparam int IDLE_PCT    = 26;
  localparam int PRINT_LIMIT = 40;

  typedef struct {
    logic [IDX_W-1:0] corner_a;
    logic [IDX_W-1:0] corner_b;
    logic [IDX_W-1:0] corner_c;
    part_t            part;
    logic             last_triangle;
  } triangle_t;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  etig_req_if req_ch();
  etig_tri_if tri_ch();

  triangle_t   pending_triangles[$];

  int unsigned ring_reg      = RING_SIZE_RST;
  int unsigned spine_reg     = SPINE_POINTS_RST;
  bit          closed_reg    = 1'b1;
  bit          loop_reg      = 1'b0;
  bit          begin_cap_reg = 1'b1;
  bit          end_cap_reg   = 1'b1;

  part_t       mesh_part  = PART_SIDE;
  int          band_idx   = 0;
  int          slot_idx   = 0;
  bit          upper_half = 1'b0;

  int          error_count     = 0;
  int          requests_sent   = 0;
  int          triangles_seen  = 0;
  int          meshes_finished = 0;
  int          settings_used   = 0;
  int          cycle_count     = 0;
  int          hold_asked      = 0;
  bit          steady          = 1'b0;

  extrusion_triangle_index_generator #(
    .MAX_RING (MAX_RING),
    .MAX_SPINE(MAX_SPINE)
  ) u_dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .request (req_ch),
    .triangle(tri_ch)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  function automatic int ring_points();
    if (ring_reg < 3) return 3;
    if (ring_reg > MAX_RING) return MAX_RING;
    return ring_reg;
  endfunction

  function automatic int spine_rings();
    if (spine_reg < 2) return 2;
    if (spine_reg > MAX_SPINE) return MAX_SPINE;
    return spine_reg;
  endfunction

  function automatic void rewind_position();
    mesh_part  = PART_SIDE;
    band_idx   = 0;
    slot_idx   = 0;
    upper_half = 1'b0;
  endfunction

  // Moves the position on until it names a triangle that exists under the
  // current shape, wrapping to the first triangle past the end of the mesh.
  function automatic void settle_position();
    int r;
    int bands;
    int quads;
    r     = ring_points();
    bands = loop_reg ? spine_rings() : spine_rings() - 1;
    quads = closed_reg ? r : r - 1;
    while (1) begin
      case (mesh_part)
        PART_SIDE: begin
          if (band_idx >= bands) begin
            mesh_part  = PART_BEGIN;
            slot_idx   = 0;
            upper_half = 1'b0;
          end else if (slot_idx >= quads) begin
            band_idx++;
            slot_idx   = 0;
            upper_half = 1'b0;
          end else begin
            return;
          end
        end
        PART_BEGIN: begin
          if (begin_cap_reg && slot_idx < r - 2) return;
          mesh_part = PART_END;
          slot_idx  = 0;
        end
        default: begin
          if (!(end_cap_reg && slot_idx < r - 2)) rewind_position();
          return;
        end
      endcase
    end
  endfunction

  function automatic triangle_t next_triangle(input bit restart);
    triangle_t t;
    int        r;
    int        s;
    int        bands;
    int        quads;
    int        i;
    int        lo;
    int        hi;
    int        inext;
    int        a;
    int        b;
    int        c;
    bit        last;
    r     = ring_points();
    s     = spine_rings();
    bands = loop_reg ? s : s - 1;
    quads = closed_reg ? r : r - 1;
    last  = 1'b0;
    if (restart) rewind_position();
    settle_position();
    i = slot_idx;
    case (mesh_part)
      PART_SIDE: begin
        lo    = band_idx * r;
        hi    = (band_idx + 1 >= s) ? 0 : lo + r;
        inext = (i + 1 >= r) ? 0 : i + 1;
        a     = lo + i;
        b     = upper_half ? hi + inext : lo + inext;
        c     = upper_half ? hi + i : hi + inext;
        last  = band_idx == bands - 1 && i == quads - 1 && upper_half &&
                !begin_cap_reg && !end_cap_reg;
        if (upper_half) slot_idx++;
        upper_half = !upper_half;
      end
      PART_BEGIN: begin
        a    = 0;
        b    = r - 1 - i;
        c    = r - 2 - i;
        last = i == r - 3 && !end_cap_reg;
        slot_idx++;
      end
      default: begin
        a    = (s - 1) * r;
        b    = a + i + 1;
        c    = a + i + 2;
        last = i == r - 3;
        slot_idx++;
      end
    endcase
    t.corner_a      = IDX_W'(a);
    t.corner_b      = IDX_W'(b);
    t.corner_c      = IDX_W'(c);
    t.part          = mesh_part;
    t.last_triangle = last;
    settle_position();
    return t;
  endfunction

  task automatic report_error(input string msg);
    if (error_count < PRINT_LIMIT) $display("ERROR at cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [IDX_W-1:0] got,
                             input logic [IDX_W-1:0] want);
    if (got !== want)
      report_error($sformatf("word %0d: %s is %0d, expected %0d", triangles_seen, name,
                             got, want));
  endtask

  task automatic check_triangle();
    triangle_t want;
    if (pending_triangles.size() == 0) begin
      report_error($sformatf("word (%0d,%0d,%0d) arrived with none expected",
                             tri_ch.corner_a, tri_ch.corner_b, tri_ch.corner_c));
      return;
    end
    want = pending_triangles.pop_front();
    triangles_seen++;
    if (want.last_triangle) meshes_finished++;
    check_field("corner_a", tri_ch.corner_a, want.corner_a);
    check_field("corner_b", tri_ch.corner_b, want.corner_b);
    check_field("corner_c", tri_ch.corner_c, want.corner_c);
    check_field("part", IDX_W'(tri_ch.part), IDX_W'(want.part));
    check_field("last_triangle", IDX_W'(tri_ch.last_triangle), IDX_W'(want.last_triangle));
  endtask

  // Receiver: takes triangle words, stalls at random and, when asked, holds
  // off for a long stretch so that the block backs up onto its input.
  initial begin
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    tri_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && tri_ch.valid === 1'b1 && tri_ch.ready === 1'b1) check_triangle();
      if (hold_seen != hold_asked) begin
        hold_seen = hold_asked;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        tri_ch.ready <= 1'b0;
      end else begin
        tri_ch.ready <= steady || $urandom_range(99) >= IDLE_PCT;
      end
    end
  end

  task automatic write_register(input reg_idx_t idx, input int unsigned value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(4 * idx);
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_RING_SIZE:    ring_reg      = value[RING_W-1:0];
      REG_SPINE_POINTS: spine_reg     = value[SPINE_W-1:0];
      REG_RING_CLOSED:  closed_reg    = value[0];
      REG_SPINE_LOOP:   loop_reg      = value[0];
      REG_BEGIN_CAP_ON: begin_cap_reg = value[0];
      REG_END_CAP_ON:   end_cap_reg   = value[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic configure_mesh(input int unsigned ring, input int unsigned spine,
                                input bit closed, input bit wrap_band,
                                input bit first_fan, input bit last_fan);
    write_register(REG_RING_SIZE, ring);
    write_register(REG_SPINE_POINTS, spine);
    write_register(REG_RING_CLOSED, 32'(closed));
    write_register(REG_SPINE_LOOP, 32'(wrap_band));
    write_register(REG_BEGIN_CAP_ON, 32'(first_fan));
    write_register(REG_END_CAP_ON, 32'(last_fan));
    settings_used++;
  endtask

  // Mostly small meshes so that whole sequences wrap, now and then a large
  // or out-of-range shape.
  task automatic pick_random_mesh();
    int unsigned ring;
    int unsigned spine;
    int          pick;
    pick = $urandom_range(9);
    if (pick < 7) ring = $urandom_range(3, 8);
    else if (pick < 9) ring = $urandom_range(63);
    else ring = MAX_RING;
    pick = $urandom_range(9);
    if (pick < 8) spine = $urandom_range(2, 4);
    else spine = $urandom_range(511);
    configure_mesh(ring, spine, 1'($urandom_range(1)), 1'($urandom_range(1)),
                   1'($urandom_range(1)), 1'($urandom_range(1)));
  endtask

  task automatic send_request(input bit restart);
    if (!steady) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        req_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    req_ch.valid   <= 1'b1;
    req_ch.restart <= restart;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    pending_triangles.insert(pending_triangles.size(), next_triangle(restart));
    requests_sent++;
  endtask

  task automatic send_random_run(input int count);
    repeat (count) send_request($urandom_range(99) < 4);
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    while (pending_triangles.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic test_reset_defaults();
    send_request(1'b1);
    send_request(1'b0);
    send_request(1'b0);
    wait_drained();
  endtask

  task automatic test_tiny_open_ring();
    configure_mesh(3, 2, 1'b0, 1'b0, 1'b0, 1'b0);
    send_request(1'b1);
    repeat (5) send_request(1'b0);
    wait_drained();
  endtask

  task automatic test_looped_caps();
    configure_mesh(0, 0, 1'b0, 1'b1, 1'b1, 1'b1);
    send_request(1'b1);
    repeat (9) send_request(1'b0);
    wait_drained();
  endtask

  task automatic test_extreme_sizes();
    configure_mesh(63, 511, 1'b1, 1'b1, 1'b1, 1'b1);
    send_request(1'b1);
    send_request(1'b0);
    send_request(1'b0);
    wait_drained();
    configure_mesh(33, 257, 1'b1, 1'b0, 1'b0, 1'b1);
    send_request(1'b0);
    send_request(1'b0);
    wait_drained();
  endtask

  task automatic test_random_meshes();
    repeat (14) begin
      pick_random_mesh();
      send_random_run($urandom_range(30, 50));
      wait_drained();
    end
  endtask

  task automatic test_steady_stream();
    pick_random_mesh();
    steady = 1'b1;
    send_random_run(150);
    wait_drained();
    steady = 1'b0;
  endtask

  task automatic test_receiver_stall();
    pick_random_mesh();
    steady = 1'b1;
    hold_asked++;
    send_random_run(40);
    wait_drained();
    steady = 1'b0;
  endtask

  initial begin
    rst            <= 1'b1;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    req_ch.valid   <= 1'b0;
    req_ch.restart <= 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_tiny_open_ring();
    test_looped_caps();
    test_extreme_sizes();
    test_random_meshes();
    test_steady_stream();
    test_receiver_stall();
    $display("Sent %0d requests and checked %0d triangle words over %0d mesh shapes,",
             requests_sent, triangles_seen, settings_used);
    $display("reaching the final triangle %0d times, with a long receiver stall.",
             meshes_finished);
    if (error_count == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

endmodule
